// ----- hw/rtl/pnf_pkg.sv -----
// ----------------------------------------------------------------------------
// pnf_pkg
// shared constants, types and codes of the numeric text formatter
// ----------------------------------------------------------------------------
package pnf_pkg;

    localparam int MAX_WIDTH   = 32;
    localparam int MAX_DIGITS  = 32;
    localparam int RESULT_CAP  = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam int WIDTH_W   = $clog2(MAX_WIDTH + 1);
    localparam int WACC_W    = $clog2(MAX_WIDTH * 10 + 10);
    localparam int DIG_W     = $clog2(MAX_DIGITS + 1);
    localparam int DIG_IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W     = $clog2(MAX_DIGITS + MAX_WIDTH + 2);
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] SIGN_BIT      = 32'h8000_0000;
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam logic [7:0]  HEX_LOWER_OFS = 8'h27;
    localparam logic [7:0]  HEX_UPPER_OFS = 8'h07;
    localparam logic [7:0]  CASE_FOLD     = 8'h20;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_B    = 8'h42;
    localparam logic [7:0] CH_UP_C    = 8'h43;
    localparam logic [7:0] CH_UP_D    = 8'h44;
    localparam logic [7:0] CH_UP_L    = 8'h4C;
    localparam logic [7:0] CH_UP_O    = 8'h4F;
    localparam logic [7:0] CH_UP_U    = 8'h55;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_L    = 8'h6C;
    localparam logic [7:0] CH_LO_X    = 8'h78;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_WIDTH,
        PH_TYPE,
        PH_WAIT
    } t_phase;

    typedef enum logic [2:0] {
        K_NONE,
        K_CHAR,
        K_BIN,
        K_OCT,
        K_SDEC,
        K_UDEC,
        K_HEX
    } t_kind;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CHAR,
        BK_GEN,
        BK_DIVQ,
        BK_DIVR,
        BK_SIZE,
        BK_EMIT
    } t_bk_state;

    // one unit of work for the back end; a plain character is a char job
    typedef struct packed {
        t_kind              kind;
        logic               zero_pad;
        logic               left_justify;
        logic [WIDTH_W-1:0] width;
        logic               hex_lower;
        logic [31:0]        arg;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- hw/rtl/printf_numeric_formatter.sv -----
// ----------------------------------------------------------------------------
// printf_numeric_formatter
// printf-style integer formatter: format characters and argument words in,
// text characters out
// ----------------------------------------------------------------------------
// The parser takes one input word per cycle while its four-entry job queue
// has room; words that produce no text only update the parse state. Each
// queued job is then fetched by the conversion engine in its idle state; a
// plain character or %c then goes straight to output. A b, o or x conversion
// generates one digit per step, a d or u conversion takes two steps per
// digit (reciprocal multiply, then remainder); a sizing step follows, then
// the emit state outputs each character, padding and sign included, as the
// output register frees. The single output register is refilled in the
// cycle it is taken, and the last character of each input word carries
// tlast.
module printf_numeric_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // fmt_char[7:0], arg_value[39:8]
    input  logic        i_s_tuser,  // cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // out_char[7:0]
    output logic        o_m_tlast
);
    import pnf_pkg::*;

    t_job    front_job;
    t_job    queue_job;
    t_q_stat qstat;
    logic    push;
    logic    pop;

    pnf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_cmd      (i_s_tuser),
        .i_fmt_char (i_s_tdata[7:0]),
        .i_arg      (i_s_tdata[39:8]),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_job      (front_job)
    );

    pnf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_stat  (qstat)
    );

    pnf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_job   (queue_job),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_char  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

endmodule

// ----- hw/rtl/pnf_front.sv -----
// ----------------------------------------------------------------------------
// pnf_front
// format parser: accepts words, tracks the field state, queues jobs
// ----------------------------------------------------------------------------
module pnf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_cmd,
    input  logic [7:0]     i_fmt_char,
    input  logic [31:0]    i_arg,
    input  pnf_pkg::t_q_stat i_qstat,
    output logic           o_push,
    output pnf_pkg::t_job  o_job
);
    import pnf_pkg::*;

    t_phase             r_phase, n_phase;
    t_kind              r_kind, n_kind;
    logic               r_zp, n_zp;
    logic               r_lj, n_lj;
    logic [WIDTH_W-1:0] r_width, n_width;
    logic               r_hexlo, n_hexlo;

    logic               accept;
    logic               do_type;
    logic [7:0]         folded;
    t_kind              type_kind;
    logic [WACC_W-1:0]  w_acc;
    t_phase             ph;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        folded = (i_fmt_char >= CH_LO_A) ? (i_fmt_char - CASE_FOLD) : i_fmt_char;
        unique case (folded)
            CH_UP_C: type_kind = K_CHAR;
            CH_UP_B: type_kind = K_BIN;
            CH_UP_O: type_kind = K_OCT;
            CH_UP_D: type_kind = K_SDEC;
            CH_UP_U: type_kind = K_UDEC;
            CH_UP_X: type_kind = K_HEX;
            default: type_kind = K_NONE;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_zp    = r_zp;
        n_lj    = r_lj;
        n_width = r_width;
        n_hexlo = r_hexlo;
        o_push  = 1'b0;
        do_type = 1'b0;
        ph      = r_phase;
        o_job   = '{kind: r_kind, zero_pad: r_zp, left_justify: r_lj, width: r_width,
                    hex_lower: r_hexlo, arg: i_arg};
        w_acc   = (WACC_W'(r_width) << 3) + (WACC_W'(r_width) << 1)
                + WACC_W'(i_fmt_char[3:0]);
        if (accept) begin
            if (i_cmd) begin
                if (r_phase == PH_WAIT) begin
                    o_push  = 1'b1;
                    n_phase = PH_IDLE;
                    n_kind  = K_NONE;
                    n_zp    = 1'b0;
                    n_lj    = 1'b0;
                    n_width = '0;
                    n_hexlo = 1'b0;
                end
            end else begin
                // a character while awaiting an argument drops the conversion
                if (r_phase == PH_WAIT) begin
                    ph      = PH_IDLE;
                    n_phase = PH_IDLE;
                    n_kind  = K_NONE;
                    n_zp    = 1'b0;
                    n_lj    = 1'b0;
                    n_width = '0;
                    n_hexlo = 1'b0;
                    w_acc   = WACC_W'(i_fmt_char[3:0]);
                end
                if (i_fmt_char == CH_NUL) begin
                    n_phase = PH_IDLE;
                    n_kind  = K_NONE;
                    n_zp    = 1'b0;
                    n_lj    = 1'b0;
                    n_width = '0;
                    n_hexlo = 1'b0;
                end else begin
                    unique case (ph)
                        PH_IDLE: begin
                            if (i_fmt_char != CH_PERCENT) begin
                                o_push = 1'b1;
                            end else begin
                                n_phase = PH_START;
                                n_kind  = K_NONE;
                                n_zp    = 1'b0;
                                n_lj    = 1'b0;
                                n_width = '0;
                                n_hexlo = 1'b0;
                            end
                        end
                        PH_START, PH_WIDTH: begin
                            if (ph == PH_START && i_fmt_char == CH_ZERO) begin
                                n_zp    = 1'b1;
                                n_phase = PH_WIDTH;
                            end else if (ph == PH_START && i_fmt_char == CH_MINUS) begin
                                n_lj    = 1'b1;
                                n_phase = PH_WIDTH;
                            end else if (i_fmt_char >= CH_ZERO && i_fmt_char <= CH_NINE) begin
                                n_width = (w_acc > WACC_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
                                                                       : w_acc[WIDTH_W-1:0];
                                n_phase = PH_WIDTH;
                            end else if (i_fmt_char == CH_LO_L || i_fmt_char == CH_UP_L) begin
                                n_phase = PH_TYPE;
                            end else begin
                                do_type = 1'b1;
                            end
                        end
                        PH_TYPE: begin
                            do_type = 1'b1;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_kind  = K_NONE;
                            n_zp    = 1'b0;
                            n_lj    = 1'b0;
                            n_width = '0;
                            n_hexlo = 1'b0;
                        end
                    endcase
                    if (do_type) begin
                        if (type_kind == K_NONE) begin
                            o_push  = 1'b1;
                            n_phase = PH_IDLE;
                            n_kind  = K_NONE;
                            n_zp    = 1'b0;
                            n_lj    = 1'b0;
                            n_width = '0;
                            n_hexlo = 1'b0;
                        end else begin
                            n_kind  = type_kind;
                            n_hexlo = (i_fmt_char == CH_LO_X);
                            n_phase = PH_WAIT;
                        end
                    end
                end
                if (o_push) begin
                    o_job = '{kind: K_CHAR, zero_pad: 1'b0, left_justify: 1'b0,
                              width: '0, hex_lower: 1'b0, arg: {24'd0, i_fmt_char}};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= K_NONE;
            r_zp    <= 1'b0;
            r_lj    <= 1'b0;
            r_width <= '0;
            r_hexlo <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_zp    <= n_zp;
            r_lj    <= n_lj;
            r_width <= n_width;
            r_hexlo <= n_hexlo;
        end
    end

endmodule

// ----- hw/rtl/pnf_queue.sv -----
// ----------------------------------------------------------------------------
// pnf_queue
// short job queue between the parser and the conversion engine
// ----------------------------------------------------------------------------
module pnf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pnf_pkg::t_job     i_job,
    input  logic              i_pop,
    output pnf_pkg::t_job     o_job,
    output pnf_pkg::t_q_stat  o_stat
);
    import pnf_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job        = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("job pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop)
        else $error("job popped from empty queue");
`endif

endmodule

// ----- hw/rtl/pnf_back.sv -----
// ----------------------------------------------------------------------------
// pnf_back
// conversion engine: digit generation, sizing and character output
// ----------------------------------------------------------------------------
module pnf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pnf_pkg::t_q_stat  i_qstat,
    input  pnf_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_char,
    output logic              o_last
);
    import pnf_pkg::*;

    t_bk_state          r_state, n_state;
    t_kind              r_kind, n_kind;
    logic               r_zp, n_zp;
    logic               r_lj, n_lj;
    logic [WIDTH_W-1:0] r_width, n_width;
    logic               r_hexlo, n_hexlo;
    logic               r_neg, n_neg;
    logic [31:0]        r_v, n_v;
    logic [28:0]        r_q, n_q;
    logic [DIG_W-1:0]   r_ndig, n_ndig;
    logic [CNT_W-1:0]   r_pad, n_pad;
    logic [CNT_W-1:0]   r_body, n_body;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [3:0]         r_dig [MAX_DIGITS];

    logic               r_ovalid;
    logic [7:0]         r_ochar;
    logic               r_olast;

    logic               out_free;
    logic               emit;
    logic [7:0]         emit_char;
    logic               emit_last;
    logic               dig_we;
    logic [3:0]         dig_wd;
    logic [63:0]        prod;
    logic [31:0]        rem;
    logic [31:0]        v_shift;
    logic [3:0]         gen_dig;
    logic               neg_in;
    logic [CNT_W-1:0]   body_c;
    logic [CNT_W-1:0]   sum_c;
    logic [CNT_W-1:0]   m;
    logic               in_body;
    logic [3:0]         dsel;
    logic [7:0]         dchar;

    assign out_free = !r_ovalid || i_ready;
    assign prod     = {32'd0, r_v} * {32'd0, RECIP10};
    assign rem      = r_v - ({r_q, 3'b000} + {2'b00, r_q, 1'b0});

    // digit index counts down from the most significant digit
    always_comb begin
        m       = r_lj ? r_cnt : (r_cnt - r_pad);
        in_body = r_lj ? (r_cnt < r_body) : (r_cnt >= r_pad);
        dsel    = r_dig[DIG_IDX_W'(r_body - CNT_W'(1) - m)];
        dchar   = CH_ZERO + {4'd0, dsel};
        if (dsel > 4'd9) begin
            dchar = dchar + (r_hexlo ? HEX_LOWER_OFS : HEX_UPPER_OFS);
        end
    end

    always_comb begin
        unique case (r_kind)
            K_BIN:   begin gen_dig = {3'd0, r_v[0]};   v_shift = r_v >> 1; end
            K_OCT:   begin gen_dig = {1'b0, r_v[2:0]}; v_shift = r_v >> 3; end
            default: begin gen_dig = r_v[3:0];         v_shift = r_v >> 4; end
        endcase
    end

    assign neg_in = (i_job.kind == K_SDEC) && ((i_job.arg & SIGN_BIT) != 32'd0);
    assign body_c = CNT_W'(r_ndig) + CNT_W'(r_neg);
    assign sum_c  = (CNT_W'(r_width) > body_c) ? CNT_W'(r_width) : body_c;

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_zp      = r_zp;
        n_lj      = r_lj;
        n_width   = r_width;
        n_hexlo   = r_hexlo;
        n_neg     = r_neg;
        n_v       = r_v;
        n_q       = r_q;
        n_ndig    = r_ndig;
        n_pad     = r_pad;
        n_body    = r_body;
        n_total   = r_total;
        n_cnt     = r_cnt;
        o_pop     = 1'b0;
        emit      = 1'b0;
        emit_char = r_v[7:0];
        emit_last = 1'b0;
        dig_we    = 1'b0;
        dig_wd    = gen_dig;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_kind  = i_job.kind;
                    n_zp    = i_job.zero_pad;
                    n_lj    = i_job.left_justify;
                    n_width = i_job.width;
                    n_hexlo = i_job.hex_lower;
                    n_neg   = neg_in;
                    n_v     = neg_in ? (32'd0 - i_job.arg) : i_job.arg;
                    n_ndig  = '0;
                    if (i_job.kind == K_CHAR) begin
                        n_state = BK_CHAR;
                    end else if (i_job.kind == K_BIN || i_job.kind == K_OCT
                                 || i_job.kind == K_HEX) begin
                        n_state = BK_GEN;
                    end else begin
                        n_state = BK_DIVQ;
                    end
                end
            end
            BK_CHAR: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    n_state   = BK_IDLE;
                end
            end
            BK_GEN: begin
                dig_we = 1'b1;
                n_ndig = r_ndig + DIG_W'(1);
                n_v    = v_shift;
                if (v_shift == 32'd0 || n_ndig == DIG_W'(MAX_DIGITS)) begin
                    n_state = BK_SIZE;
                end
            end
            BK_DIVQ: begin
                n_q     = prod[63:35];
                n_state = BK_DIVR;
            end
            BK_DIVR: begin
                dig_we  = 1'b1;
                dig_wd  = rem[3:0];
                n_ndig  = r_ndig + DIG_W'(1);
                n_v     = {3'd0, r_q};
                if (r_q == 29'd0 || n_ndig == DIG_W'(MAX_DIGITS)) begin
                    n_state = BK_SIZE;
                end else begin
                    n_state = BK_DIVQ;
                end
            end
            BK_SIZE: begin
                n_body  = body_c;
                n_pad   = sum_c - body_c;
                n_total = (sum_c > CNT_W'(RESULT_CAP)) ? CNT_W'(RESULT_CAP) : sum_c;
                n_cnt   = '0;
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (!in_body) begin
                        emit_char = (r_lj || !r_zp) ? CH_SPACE : CH_ZERO;
                    end else if (r_neg && m == '0) begin
                        emit_char = CH_MINUS;
                    end else begin
                        emit_char = dchar;
                    end
                    emit_last = (r_cnt + CNT_W'(1) == r_total);
                    n_cnt     = r_cnt + CNT_W'(1);
                    if (emit_last) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (dig_we) begin
            r_dig[r_ndig[DIG_IDX_W-1:0]] <= dig_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_zp    <= n_zp;
        r_lj    <= n_lj;
        r_width <= n_width;
        r_hexlo <= n_hexlo;
        r_neg   <= n_neg;
        r_v     <= n_v;
        r_q     <= n_q;
        r_ndig  <= n_ndig;
        r_pad   <= n_pad;
        r_body  <= n_body;
        r_total <= n_total;
        r_cnt   <= n_cnt;
        if (emit) begin
            r_ochar <= emit_char;
            r_olast <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_char  = r_ochar;
    assign o_last  = r_olast;

`ifndef SYNTHESIS
    a_digits_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SIZE) |-> (r_ndig != '0) && (r_ndig <= DIG_W'(MAX_DIGITS)))
        else $error("digit count out of range");
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_EMIT) |-> (r_total != '0) && (r_cnt < r_total))
        else $error("output count beyond field total");
    a_decimal_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIVR) |-> (rem < 32'd10))
        else $error("decimal remainder out of range");
`endif

endmodule
